// ===== design/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Types, constants and helpers shared by the trapezoid motion profile blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

  localparam int FracBits  = 16;
  localparam int TickShift = 24;

  localparam int MinCreepRaw = ((1 << FracBits) + 50000) / 100000;
  localparam int MinCreep    = (MinCreepRaw > 0) ? MinCreepRaw : 1;

  localparam logic [30:0] MaxSpeedReset = 31'd65536;
  localparam logic [30:0] AccelReset    = 31'd65536;
  localparam logic [23:0] TickReset     = 24'd167772;
  localparam longint      StepResetL    = (longint'(AccelReset) * longint'(TickReset))
                                          >>> TickShift;
  localparam logic [30:0] StepReset     = 31'(StepResetL);

  localparam logic signed [35:0] SatHi = 36'sd2147483647;
  localparam logic signed [35:0] SatLo = -36'sd2147483648;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_ACCEL     = 2'd1,
    CFG_TICK      = 2'd2
  } cfg_idx_e;

  typedef enum logic [8:0] {
    SEG_IDLE    = 9'b0_0000_0001,
    SEG_ACC_P   = 9'b0_0000_0010,
    SEG_CRU_P   = 9'b0_0000_0100,
    SEG_DEC_P   = 9'b0_0000_1000,
    SEG_CONST_P = 9'b0_0001_0000,
    SEG_ACC_N   = 9'b0_0010_0000,
    SEG_CRU_N   = 9'b0_0100_0000,
    SEG_DEC_N   = 9'b0_1000_0000,
    SEG_CONST_N = 9'b1_0000_0000
  } seg_e;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [30:0] speed_step;
    logic [23:0] tick_time;
    logic        accel_zero;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               load_target;
    logic signed [31:0] target;
    logic               stop_request;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tmp_cfg.sv =====
// ----------------------------------------------------------------------------
// tmp_cfg
// Configuration registers and the per-tick speed step formed on each write.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_cfg import tmp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [30:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  logic [30:0] max_speed_q;
  logic [30:0] accel_q;
  logic [23:0] tick_q;
  logic [30:0] step_q;
  logic [30:0] accel_op;
  logic [23:0] tick_op;
  logic [54:0] step_prod;
  cfg_idx_e    idx;

  assign idx       = cfg_idx_e'(cfg_index_i);
  assign accel_op  = (idx == CFG_ACCEL) ? cfg_wdata_i : accel_q;
  assign tick_op   = (idx == CFG_TICK) ? cfg_wdata_i[23:0] : tick_q;
  assign step_prod = 55'(accel_op) * 55'(tick_op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
      accel_q     <= AccelReset;
      tick_q      <= TickReset;
      step_q      <= StepReset;
    end else if (cfg_we_i) begin
      unique case (idx)
        CFG_MAX_SPEED: begin
          max_speed_q <= cfg_wdata_i;
          step_q      <= step_prod[54:24];
        end
        CFG_ACCEL: begin
          accel_q <= cfg_wdata_i;
          step_q  <= step_prod[54:24];
        end
        CFG_TICK: begin
          tick_q <= cfg_wdata_i[23:0];
          step_q <= step_prod[54:24];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.max_speed  = max_speed_q;
  assign cfg_o.speed_step = step_q;
  assign cfg_o.tick_time  = tick_q;
  assign cfg_o.accel_zero = (accel_q == '0);

endmodule

`default_nettype wire

// ===== design/tmp_core.sv =====
// ----------------------------------------------------------------------------
// tmp_core
// Profile state and single-tick update; the state registers are the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_core import tmp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire item_t       item_i,
  input  wire logic        adv_i,
  output logic             out_valid_o,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic             done_res_o
);

  localparam logic signed [31:0] Creep = 32'(MinCreep);

  seg_e               seg_q, seg_d, seg_b;
  logic               neg_q, neg_d;
  logic               stop_q, stop_d;
  logic               out_valid_q;
  logic signed [31:0] start_q, start_d;
  logic signed [31:0] pos_q, pos_d;
  logic signed [31:0] sw_q, sw_d;
  logic signed [31:0] vel_q, vel_d;
  logic signed [31:0] last_q, last_d;
  logic signed [31:0] dest_q, dest_d;

  logic               fire;
  logic               halt;
  logic               arrived;
  logic signed [32:0] diff;
  logic [31:0]        diff_mag;
  logic [31:0]        half;
  logic signed [35:0] vmax_w;
  logic signed [35:0] step_w;
  logic signed [35:0] half_w;
  logic [31:0]        vel_mag;
  logic [55:0]        trav_prod;
  logic signed [35:0] trav;

  assign fire   = adv_i & item_i.valid;
  assign vmax_w = 36'(signed'({1'b0, cfg_i.max_speed}));
  assign step_w = 36'(signed'({1'b0, cfg_i.speed_step}));

  always_comb begin
    dest_d  = item_i.load_target ? item_i.target : dest_q;
    stop_d  = stop_q | item_i.stop_request;
    last_d  = last_q;
    start_d = start_q;
    pos_d   = pos_q;
    sw_d    = sw_q;
    vel_d   = vel_q;
    neg_d   = neg_q;
    seg_d   = seg_q;
    halt    = 1'b0;
    arrived = 1'b0;

    // new target: move starts from the previous target
    diff     = 33'(dest_d) - 33'(last_q);
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    half     = 32'((33'(diff_mag) + 33'd1) >> 1);
    half_w   = 36'(signed'({1'b0, half}));
    if (dest_d != last_q) begin
      start_d = last_q;
      pos_d   = last_q;
      last_d  = dest_d;
      neg_d   = diff[32];
      sw_d    = diff[32] ? 32'(36'(last_q) - half_w) : 32'(36'(last_q) + half_w);
      if (cfg_i.accel_zero) begin
        vel_d = diff[32] ? 32'(-vmax_w) : 32'(vmax_w);
        seg_d = diff[32] ? SEG_CONST_N : SEG_CONST_P;
      end else begin
        seg_d = diff[32] ? SEG_ACC_N : SEG_ACC_P;
      end
    end

    if (stop_d) begin
      if (vel_d > 0) begin
        seg_d = SEG_DEC_P;
      end else if (vel_d < 0) begin
        seg_d = SEG_DEC_N;
      end else begin
        stop_d = 1'b0;
      end
    end

    seg_b = seg_d;
    unique case (seg_b)
      SEG_IDLE, SEG_CONST_P, SEG_CONST_N: begin
      end
      SEG_ACC_P: begin
        vel_d = sat32(36'(vel_d) + step_w);
        if (36'(vel_d) >= vmax_w) begin
          sw_d  = sat32(36'(dest_d) - (36'(pos_d) - 36'(start_d)));
          seg_d = SEG_CRU_P;
        end else if (pos_d >= sw_d) begin
          seg_d = SEG_DEC_P;
        end
      end
      SEG_CRU_P: begin
        if (pos_d >= sw_d) seg_d = SEG_DEC_P;
      end
      SEG_DEC_P: begin
        vel_d = sat32(36'(vel_d) - step_w);
        if (stop_d) begin
          if (vel_d <= Creep) halt = 1'b1;
        end else if (vel_d < Creep) begin
          vel_d = Creep;
        end
      end
      SEG_ACC_N: begin
        vel_d = sat32(36'(vel_d) - step_w);
        if (-36'(vel_d) >= vmax_w) begin
          sw_d  = sat32(36'(dest_d) - (36'(pos_d) - 36'(start_d)));
          seg_d = SEG_CRU_N;
        end else if (pos_d <= sw_d) begin
          seg_d = SEG_DEC_N;
        end
      end
      SEG_CRU_N: begin
        if (pos_d <= sw_d) seg_d = SEG_DEC_N;
      end
      SEG_DEC_N: begin
        vel_d = sat32(36'(vel_d) + step_w);
        if (stop_d) begin
          if (vel_d >= -Creep) halt = 1'b1;
        end else if (vel_d > -Creep) begin
          vel_d = -Creep;
        end
      end
      default: seg_d = SEG_IDLE;
    endcase

    // controlled stop reached: hold here
    if (halt) begin
      seg_d   = SEG_IDLE;
      stop_d  = 1'b0;
      dest_d  = pos_d;
      last_d  = pos_d;
      start_d = pos_d;
      sw_d    = pos_d;
    end

    // position step, magnitude truncated toward zero
    vel_mag   = vel_d[31] ? 32'(-33'(vel_d)) : vel_d;
    trav_prod = 56'(vel_mag) * 56'(cfg_i.tick_time);
    trav      = vel_d[31] ? -36'(signed'({4'b0, trav_prod[55:24]}))
                          : 36'(signed'({4'b0, trav_prod[55:24]}));

    if (seg_d != SEG_IDLE) begin
      pos_d   = sat32(36'(pos_d) + trav);
      arrived = neg_d ? (pos_d <= dest_d) : (pos_d >= dest_d);
      if (arrived) begin
        pos_d  = dest_d;
        vel_d  = '0;
        last_d = dest_d;
        seg_d  = SEG_IDLE;
      end
    end else begin
      vel_d = '0;
      pos_d = dest_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_IDLE;
      neg_q       <= 1'b0;
      stop_q      <= 1'b0;
      start_q     <= '0;
      pos_q       <= '0;
      sw_q        <= '0;
      vel_q       <= '0;
      last_q      <= '0;
      dest_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_i) out_valid_q <= item_i.valid;
      if (fire) begin
        seg_q   <= seg_d;
        neg_q   <= neg_d;
        stop_q  <= stop_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        sw_q    <= sw_d;
        vel_q   <= vel_d;
        last_q  <= last_d;
        dest_q  <= dest_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign velocity_o  = vel_q;
  assign done_res_o  = (seg_q == SEG_IDLE);

`ifndef NO_ASSERTIONS
  a_idle_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q == SEG_IDLE |-> vel_q == '0)
    else $error("idle profile with nonzero velocity");

  a_idle_on_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q == SEG_IDLE |-> pos_q == dest_q)
    else $error("idle profile away from destination");

  a_hold_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pos_q) && $stable(vel_q) && $stable(seg_q))
    else $error("profile state moved without a transaction");
`endif

endmodule

`default_nettype wire

// ===== design/trapezoid_motion_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Per-tick trapezoidal position profile generator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction per control tick carrying load_target,
//   target and stop_request; output channel: one transaction per tick with
//   position, velocity and done_res.
//   both channels use valid/stall; a transaction completes when valid is
//   high and stall is low.
//   pipeline: an accepted tick is held in the input register, and its
//   result is registered in the core state registers when the output is free.
//   throughput: one tick per cycle while the output is not stalled, set by
//   the velocity and position update loop in the core.
//   configuration: writes on cfg_we_i take effect at once, the speed step
//   is formed on the write; write only when no tick is in flight.
//   reset: profile idle at position zero, registers at their defaults.
//   output stall: the result holds; an empty input register still takes one
//   more tick, after that in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_profile import tmp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               load_target_i,
  input  wire logic signed [31:0] target_i,
  input  wire logic               stop_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      position_o,
  output logic signed [31:0]      velocity_o,
  output logic                    done_res_o
);

  cfg_t  cfg;
  item_t item_q;
  logic  adv;

  assign adv        = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = item_q.valid & ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (!in_stall_o) begin
      item_q.valid <= in_valid_i;
      if (in_valid_i) begin
        item_q.load_target  <= load_target_i;
        item_q.target       <= target_i;
        item_q.stop_request <= stop_request_i;
      end
    end
  end

  tmp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tmp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_q),
    .adv_i       (adv),
    .out_valid_o (out_valid_o),
    .position_o  (position_o),
    .velocity_o  (velocity_o),
    .done_res_o  (done_res_o)
  );

endmodule

`default_nettype wire
